// File: rtl/mwcf_pkg.sv
// ----------------------------------------------------------------------------
// Minimum weight cycle finder package
// Shared widths, types and helpers for the cycle finder blocks.
// ----------------------------------------------------------------------------
package mwcf_pkg;

  localparam int unsigned MAX_NODES = 64;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned CELL_W    = 2 * IDX_W;
  localparam int unsigned NODE_W    = 7;
  localparam int unsigned WGT_W     = 16;
  localparam int unsigned DIST_W    = 24;
  localparam logic [DIST_W-1:0] INF_DIST = {DIST_W{1'b1}};
  localparam logic [NODE_W-1:0] MAX_NODE_V = NODE_W'(MAX_NODES);

  typedef struct packed {
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [WGT_W-1:0]  weight;
    logic              last_edge;
  } mwcf_edge_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              found;
    logic [DIST_W-1:0] cycle_length;
    logic              last;
  } mwcf_res_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_LD_RD, ST_LD_CMP, ST_LD_WR2, ST_IN_RD, ST_IN_WR,
    ST_CY_START, ST_CY_RD1, ST_CY_RD2, ST_CY_CMP, ST_W_RD, ST_W_CHK,
    ST_W_POP, ST_W_POPD, ST_W_PV, ST_ADD_J, ST_ADD_K, ST_RX_A, ST_RX_B,
    ST_RX_C, ST_RX_D, ST_OUT_RD, ST_OUT_PUSH
  } mwcf_state_e;

  function automatic logic [CELL_W-1:0] cell_idx(logic [NODE_W-1:0] a,
                                                 logic [NODE_W-1:0] b);
    logic [NODE_W-1:0] am;
    logic [NODE_W-1:0] bm;
    am = a - NODE_W'(1);
    bm = b - NODE_W'(1);
    return {am[IDX_W-1:0], bm[IDX_W-1:0]};
  endfunction

  function automatic logic node_ok(logic [NODE_W-1:0] v);
    return (v != '0) && (v <= MAX_NODE_V);
  endfunction

endpackage

// File: rtl/mwcf_sat_add.sv
// ----------------------------------------------------------------------------
// Saturating adder and comparator
// Adds two distances with saturation at infinity and compares the sum.
// ----------------------------------------------------------------------------
module mwcf_sat_add (
  input  logic [mwcf_pkg::DIST_W-1:0] a_i,
  input  logic [mwcf_pkg::DIST_W-1:0] b_i,
  input  logic [mwcf_pkg::DIST_W-1:0] cmp_i,
  output logic [mwcf_pkg::DIST_W-1:0] sum_o,
  output logic                        less_o
);
  import mwcf_pkg::*;

  logic [DIST_W:0] raw;

  assign raw = {1'b0, a_i} + {1'b0, b_i};

  always_comb begin
    if (a_i == INF_DIST || b_i == INF_DIST || raw >= {1'b0, INF_DIST}) begin
      sum_o = INF_DIST;
    end else begin
      sum_o = raw[DIST_W-1:0];
    end
  end

  assign less_o = sum_o < cmp_i;

endmodule

// File: rtl/mwcf_engine.sv
// ----------------------------------------------------------------------------
// Cycle finder engine
// Edge store, all-pairs search, path walk and result sequencing.
// ----------------------------------------------------------------------------
module mwcf_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [mwcf_pkg::NODE_W-1:0]  node_count_i,
  input  logic                         edge_valid_i,
  input  mwcf_pkg::mwcf_edge_t         edge_i,
  output logic                         edge_ready_o,
  output logic                         res_valid_o,
  output mwcf_pkg::mwcf_res_t          res_o,
  input  logic                         res_ready_i
);
  import mwcf_pkg::*;

  logic [DIST_W-1:0] ew_mem   [2**CELL_W];
  logic [DIST_W-1:0] dist_mem [2**CELL_W];
  logic [NODE_W-1:0] via_mem  [2**CELL_W];
  logic [2*NODE_W-1:0] stk_mem [MAX_NODES];
  logic [NODE_W-1:0] cn_mem   [MAX_NODES];

  mwcf_state_e state_q, state_d;
  logic [NODE_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d, n_q, n_d;
  logic [NODE_W-1:0] a_q, a_d, b_q, b_d, sp_q, sp_d, cnt_q, cnt_d, r_q, r_d;
  logic [DIST_W-1:0] best_q, best_d, acc_q, acc_d, dik_q, dik_d, dkj_q, dkj_d;
  logic [CELL_W-1:0] clr_q, clr_d;
  mwcf_edge_t        e_q, e_d;
  logic              upd_q, upd_d;

  logic [CELL_W-1:0] ew_raddr, ew_waddr, d_raddr, d_waddr, v_raddr, v_waddr;
  logic              ew_we, d_we, v_we, stk_we, cn_we;
  logic [DIST_W-1:0] ew_wdata, d_wdata, ew_rd, d_rd;
  logic [NODE_W-1:0] v_wdata, v_rd, cn_rd, cn_wdata;
  logic [IDX_W-1:0]  stk_waddr, stk_raddr, cn_waddr, cn_raddr;
  logic [2*NODE_W-1:0] stk_wdata, stk_rd;

  logic [DIST_W-1:0] su_a, su_b, su_c, su_sum;
  logic              su_less;

  mwcf_sat_add u_sat (
    .a_i(su_a), .b_i(su_b), .cmp_i(su_c), .sum_o(su_sum), .less_o(su_less)
  );

  always_ff @(posedge clk_i) begin
    if (ew_we) ew_mem[ew_waddr] <= ew_wdata;
    if (d_we) dist_mem[d_waddr] <= d_wdata;
    if (v_we) via_mem[v_waddr] <= v_wdata;
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (cn_we) cn_mem[cn_waddr] <= cn_wdata;
    ew_rd  <= ew_mem[ew_raddr];
    d_rd   <= dist_mem[d_raddr];
    v_rd   <= via_mem[v_raddr];
    stk_rd <= stk_mem[stk_raddr];
    cn_rd  <= cn_mem[cn_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q   <= '0;
      cnt_q   <= '0;
      best_q  <= INF_DIST;
      sp_q    <= '0;
      r_q     <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      best_q  <= best_d;
      sp_q    <= sp_d;
      r_q     <= r_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; k_q <= k_d; n_q <= n_d;
    a_q <= a_d; b_q <= b_d;
    acc_q <= acc_d; dik_q <= dik_d; dkj_q <= dkj_d;
    e_q <= e_d; upd_q <= upd_d;
  end

  // Next state and sequencing registers.
  always_comb begin
    logic last_pair;
    last_pair = (i_q == n_q) && (j_q == n_q);
    state_d = state_q;
    i_d = i_q; j_d = j_q; k_d = k_q; n_d = n_q;
    a_d = a_q; b_d = b_q; sp_d = sp_q; cnt_d = cnt_q; r_d = r_q;
    best_d = best_q; acc_d = acc_q; dik_d = dik_q; dkj_d = dkj_q;
    clr_d = clr_q; e_d = e_q; upd_d = upd_q;
    case (state_q)
      ST_CLR: begin
        clr_d = clr_q + CELL_W'(1);
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (edge_valid_i) begin
          e_d = edge_i;
          state_d = ST_LD_RD;
        end
      end
      ST_LD_RD: state_d = ST_LD_CMP;
      ST_LD_CMP: begin
        upd_d = node_ok(e_q.node_a) && node_ok(e_q.node_b) &&
                (e_q.node_a != e_q.node_b) &&
                ({{(DIST_W-WGT_W){1'b0}}, e_q.weight} < ew_rd);
        state_d = ST_LD_WR2;
      end
      ST_LD_WR2: begin
        if (e_q.last_edge) begin
          if (node_count_i == '0) n_d = NODE_W'(1);
          else if (node_count_i > MAX_NODE_V) n_d = MAX_NODE_V;
          else n_d = node_count_i;
          i_d = NODE_W'(1);
          j_d = NODE_W'(1);
          state_d = ST_IN_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_IN_RD: state_d = ST_IN_WR;
      ST_IN_WR: begin
        if (last_pair) begin
          best_d = INF_DIST;
          cnt_d = '0;
          k_d = NODE_W'(1);
          state_d = ST_CY_START;
        end else begin
          if (j_q == n_q) begin
            i_d = i_q + NODE_W'(1);
            j_d = NODE_W'(1);
          end else begin
            j_d = j_q + NODE_W'(1);
          end
          state_d = ST_IN_RD;
        end
      end
      ST_CY_START: begin
        if (k_q >= NODE_W'(3)) begin
          i_d = NODE_W'(1);
          j_d = NODE_W'(2);
          state_d = ST_CY_RD1;
        end else begin
          i_d = NODE_W'(1);
          j_d = NODE_W'(1);
          state_d = ST_RX_A;
        end
      end
      ST_CY_RD1: state_d = ST_CY_RD2;
      ST_CY_RD2: begin
        acc_d = su_sum;
        state_d = ST_CY_CMP;
      end
      ST_CY_CMP: begin
        if (su_less) begin
          best_d = su_sum;
          cnt_d = NODE_W'(1);
          a_d = i_q;
          b_d = j_q;
          sp_d = '0;
          state_d = ST_W_RD;
        end else begin
          state_d = ST_ADD_K;
        end
      end
      ST_W_RD: state_d = ST_W_CHK;
      ST_W_CHK: begin
        if (v_rd != '0 && !sp_q[IDX_W]) begin
          sp_d = sp_q + NODE_W'(1);
          b_d = v_rd;
          state_d = ST_W_RD;
        end else if (sp_q == '0 || cnt_q[IDX_W]) begin
          state_d = ST_ADD_J;
        end else begin
          state_d = ST_W_POP;
        end
      end
      ST_W_POP: begin
        sp_d = sp_q - NODE_W'(1);
        state_d = ST_W_POPD;
      end
      ST_W_POPD: begin
        a_d = stk_rd[2*NODE_W-1:NODE_W];
        b_d = stk_rd[NODE_W-1:0];
        state_d = ST_W_PV;
      end
      ST_W_PV: begin
        if (!cnt_q[IDX_W]) cnt_d = cnt_q + NODE_W'(1);
        a_d = v_rd;
        state_d = ST_W_RD;
      end
      ST_ADD_J: begin
        if (!cnt_q[IDX_W]) cnt_d = cnt_q + NODE_W'(1);
        state_d = ST_ADD_K;
        upd_d = 1'b1;
      end
      ST_ADD_K: begin
        if (upd_q && !cnt_q[IDX_W]) cnt_d = cnt_q + NODE_W'(1);
        upd_d = 1'b0;
        if (j_q + NODE_W'(1) < k_q) begin
          j_d = j_q + NODE_W'(1);
          state_d = ST_CY_RD1;
        end else if (i_q + NODE_W'(2) < k_q) begin
          i_d = i_q + NODE_W'(1);
          j_d = i_q + NODE_W'(2);
          state_d = ST_CY_RD1;
        end else begin
          i_d = NODE_W'(1);
          j_d = NODE_W'(1);
          state_d = ST_RX_A;
        end
      end
      ST_RX_A: state_d = ST_RX_B;
      ST_RX_B: begin
        dik_d = d_rd;
        state_d = ST_RX_C;
      end
      ST_RX_C: begin
        dkj_d = d_rd;
        state_d = ST_RX_D;
      end
      ST_RX_D: begin
        if (last_pair) begin
          if (k_q == n_q) begin
            r_d = '0;
            state_d = ST_OUT_RD;
          end else begin
            k_d = k_q + NODE_W'(1);
            state_d = ST_CY_START;
          end
        end else begin
          if (j_q == n_q) begin
            i_d = i_q + NODE_W'(1);
            j_d = NODE_W'(1);
          end else begin
            j_d = j_q + NODE_W'(1);
          end
          state_d = ST_RX_A;
        end
      end
      ST_OUT_RD: state_d = ST_OUT_PUSH;
      ST_OUT_PUSH: begin
        if (res_ready_i) begin
          if (res_o.last) begin
            clr_d = '0;
            state_d = ST_CLR;
          end else begin
            r_d = r_q + NODE_W'(1);
            state_d = ST_OUT_RD;
          end
        end
      end
      default: state_d = ST_CLR;
    endcase
  end

  // Memory ports, shared unit operands and handshake outputs.
  always_comb begin
    logic found;
    found = (best_q != INF_DIST);
    ew_raddr = cell_idx(e_q.node_a, e_q.node_b);
    ew_we = 1'b0; ew_waddr = clr_q; ew_wdata = INF_DIST;
    d_raddr = cell_idx(i_q, j_q);
    d_we = 1'b0; d_waddr = cell_idx(i_q, j_q); d_wdata = su_sum;
    v_raddr = cell_idx(a_q, b_q);
    v_we = 1'b0; v_waddr = cell_idx(i_q, j_q); v_wdata = k_q;
    stk_we = 1'b0; stk_waddr = sp_q[IDX_W-1:0]; stk_wdata = {a_q, b_q};
    stk_raddr = sp_q[IDX_W-1:0] - IDX_W'(1);
    cn_we = 1'b0; cn_waddr = cnt_q[IDX_W-1:0]; cn_wdata = i_q;
    cn_raddr = r_q[IDX_W-1:0];
    su_a = '0; su_b = '0; su_c = '0;
    edge_ready_o = (state_q == ST_IDLE);
    res_valid_o = 1'b0;
    res_o.node = found ? cn_rd : '0;
    res_o.found = found;
    res_o.cycle_length = found ? best_q : '0;
    res_o.last = !found || (r_q + NODE_W'(1) == cnt_q);
    case (state_q)
      ST_CLR: ew_we = 1'b1;
      ST_LD_WR2: begin
        ew_we = upd_q;
        ew_waddr = cell_idx(e_q.node_b, e_q.node_a);
        ew_wdata = {{(DIST_W-WGT_W){1'b0}}, e_q.weight};
      end
      ST_LD_CMP: begin
        ew_we = node_ok(e_q.node_a) && node_ok(e_q.node_b) &&
                (e_q.node_a != e_q.node_b) &&
                ({{(DIST_W-WGT_W){1'b0}}, e_q.weight} < ew_rd);
        ew_waddr = cell_idx(e_q.node_a, e_q.node_b);
        ew_wdata = {{(DIST_W-WGT_W){1'b0}}, e_q.weight};
      end
      ST_IN_RD: ew_raddr = cell_idx(i_q, j_q);
      ST_IN_WR: begin
        d_we = 1'b1;
        d_wdata = (i_q == j_q) ? '0 : ew_rd;
        v_we = 1'b1;
        v_wdata = '0;
      end
      ST_CY_RD1: ew_raddr = cell_idx(j_q, k_q);
      ST_CY_RD2: begin
        ew_raddr = cell_idx(k_q, i_q);
        su_a = d_rd;
        su_b = ew_rd;
      end
      ST_CY_CMP: begin
        su_a = acc_q;
        su_b = ew_rd;
        su_c = best_q;
        cn_we = su_less;
        cn_waddr = '0;
        cn_wdata = i_q;
      end
      ST_W_CHK: stk_we = (v_rd != '0) && !sp_q[IDX_W];
      ST_W_POPD: v_raddr = cell_idx(stk_rd[2*NODE_W-1:NODE_W], stk_rd[NODE_W-1:0]);
      ST_W_PV: begin
        cn_we = !cnt_q[IDX_W];
        cn_wdata = v_rd;
      end
      ST_ADD_J: begin
        cn_we = !cnt_q[IDX_W];
        cn_wdata = j_q;
      end
      ST_ADD_K: begin
        cn_we = upd_q && !cnt_q[IDX_W];
        cn_wdata = k_q;
      end
      ST_RX_A: d_raddr = cell_idx(i_q, k_q);
      ST_RX_B: d_raddr = cell_idx(k_q, j_q);
      ST_RX_C: d_raddr = cell_idx(i_q, j_q);
      ST_RX_D: begin
        su_a = dik_q;
        su_b = dkj_q;
        su_c = d_rd;
        d_we = su_less;
        v_we = su_less;
      end
      ST_OUT_PUSH: res_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

// File: rtl/minimum_weight_cycle_finder_unit.sv
// ----------------------------------------------------------------------------
// Minimum weight cycle finder
// Loads undirected weighted edges and reports the lightest cycle node by node.
// ----------------------------------------------------------------------------
// Edges arrive on the slave stream, one item each, with the last edge flagged
// by tlast. Loading an edge reads the stored weight, compares, then writes
// both directions, and takes no new edge until then. The flagged edge starts
// an all-pairs search over node_count nodes, with a path walk on each
// improvement, using one shared saturating adder and dual-port memories.
// Results leave on the master stream: one item per cycle node, each read from
// memory and then handed off, or one item with found cleared when there is
// no cycle. tlast marks the final item of a run.
// After reset and after every run the edge store is swept back to infinity,
// during which no edge is taken; node_count writes are always taken. A stalled
// receiver holds the output register and pauses the engine.
// ----------------------------------------------------------------------------
module minimum_weight_cycle_finder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,     // node_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // node_a, node_b, weight, zero fill
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // node, cycle_length, zero fill
  output logic        m_axis_tuser,   // found
  output logic        m_axis_tlast
);
  import mwcf_pkg::*;

  logic [NODE_W-1:0] node_count_q;
  mwcf_edge_t        edge_in;
  mwcf_res_t         res, out_q;
  logic              res_valid, res_ready, out_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= MAX_NODE_V;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) node_count_q <= cfg_data_i;
      if (res_ready) out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign res_ready = !out_valid_q || m_axis_tready;

  assign edge_in.node_a    = s_axis_tdata[6:0];
  assign edge_in.node_b    = s_axis_tdata[13:7];
  assign edge_in.weight    = s_axis_tdata[29:14];
  assign edge_in.last_edge = s_axis_tlast;

  mwcf_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .node_count_i (node_count_q),
    .edge_valid_i (s_axis_tvalid),
    .edge_i       (edge_in),
    .edge_ready_o (s_axis_tready),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.cycle_length, out_q.node};
  assign m_axis_tuser  = out_q.found;
  assign m_axis_tlast  = out_q.last;

`ifndef SYNTHESIS
  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !res_valid) else $error("result while taking edges");
  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0))
    else $error("bad no-cycle result");
  a_found_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[6:0] != '0))
    else $error("cycle node zero");
`endif

endmodule

// File: dv/minimum_weight_cycle_finder_unit_test.sv
// ----------------------------------------------------------------------------
// Minimum weight cycle finder testbench
// Streams edge items into the block and checks every cycle node it reports
// against an in-bench all-pairs search over the same edges, under random
// stalls on both streams and several node counts.
// ----------------------------------------------------------------------------
module minimum_weight_cycle_finder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mwcf_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 8000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  minimum_weight_cycle_finder_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  mwcf_edge_t  edge_q[$];
  mwcf_res_t   cycle_q[$];
  mwcf_edge_t  cur_edge;
  logic [23:0] edge_len[4096];
  logic [23:0] dist_len[4096];
  logic [6:0]  via_tab[4096];
  logic [6:0]  cyc_nodes[64];
  int          cyc_cnt;
  logic [23:0] best_len;
  int          count_m = 64;
  int          mismatches = 0;
  int          src_gap = 0;
  int          sink_gap = 0;
  int          hold_cnt = 0;
  bit          hold_req = 0;
  bit          hold_done = 0;
  bit          quiet = 0;
  int          cycles = 0;
  int          total_items = 0;

  function automatic bit node_in(int v);
    return v >= 1 && v <= 64;
  endfunction

  function automatic int pos(int a, int b);
    return (a - 1) * 64 + (b - 1);
  endfunction

  function automatic int via_at(int a, int b);
    if (!node_in(a) || !node_in(b)) return 0;
    return int'(via_tab[pos(a, b)]);
  endfunction

  function automatic logic [23:0] sat_sum(logic [23:0] a, logic [23:0] b);
    logic [24:0] s;
    if (a == INF_DIST || b == INF_DIST) return INF_DIST;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, INF_DIST}) ? INF_DIST : s[23:0];
  endfunction

  task automatic push_node(int v);
    if (cyc_cnt < 64) begin
      cyc_nodes[cyc_cnt] = v[6:0];
      cyc_cnt++;
    end
  endtask

  task automatic walk_path(int x, int y);
    logic [13:0] stk[64];
    int sp, a, b, p;
    sp = 0;
    a = x;
    b = y;
    forever begin
      while (via_at(a, b) != 0 && sp < 64) begin
        stk[sp] = {a[6:0], b[6:0]};
        sp++;
        b = via_at(a, b);
      end
      if (sp == 0 || cyc_cnt >= 64) break;
      sp--;
      a = int'(stk[sp][13:7]);
      b = int'(stk[sp][6:0]);
      p = via_at(a, b);
      push_node(p);
      a = p;
    end
  endtask

  task automatic find_cycle();
    int n;
    logic [23:0] s;
    mwcf_res_t r;
    n = count_m;
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    for (int i = 1; i <= n; i++)
      for (int j = 1; j <= n; j++) begin
        dist_len[pos(i, j)] = (i == j) ? '0 : edge_len[pos(i, j)];
        via_tab[pos(i, j)] = '0;
      end
    best_len = INF_DIST;
    cyc_cnt = 0;
    for (int k = 1; k <= n; k++) begin
      for (int i = 1; i < k; i++)
        for (int j = i + 1; j < k; j++) begin
          s = sat_sum(sat_sum(dist_len[pos(i, j)], edge_len[pos(j, k)]),
                      edge_len[pos(k, i)]);
          if (best_len > s) begin
            best_len = s;
            cyc_cnt = 0;
            push_node(i);
            walk_path(i, j);
            push_node(j);
            push_node(k);
          end
        end
      for (int i = 1; i <= n; i++)
        for (int j = 1; j <= n; j++) begin
          s = sat_sum(dist_len[pos(i, k)], dist_len[pos(k, j)]);
          if (dist_len[pos(i, j)] > s) begin
            dist_len[pos(i, j)] = s;
            via_tab[pos(i, j)] = k[6:0];
          end
        end
    end
    for (int i = 0; i < 4096; i++) edge_len[i] = INF_DIST;
    if (best_len >= INF_DIST || cyc_cnt == 0) begin
      r = '{node: '0, found: 1'b0, cycle_length: '0, last: 1'b1};
      cycle_q.push_back(r);
    end else begin
      for (int i = 0; i < cyc_cnt; i++) begin
        r.node = cyc_nodes[i];
        r.found = 1'b1;
        r.cycle_length = best_len;
        r.last = (i + 1 == cyc_cnt);
        cycle_q.push_back(r);
      end
    end
  endtask

  task automatic take_edge(mwcf_edge_t e);
    int a, b;
    a = int'(e.node_a);
    b = int'(e.node_b);
    if (node_in(a) && node_in(b) && a != b && e.weight < edge_len[pos(a, b)]) begin
      edge_len[pos(a, b)] = {8'h00, e.weight};
      edge_len[pos(b, a)] = {8'h00, e.weight};
    end
    if (e.last_edge) find_cycle();
  endtask

  always @(posedge clk_i) begin
    if (s_tvalid && s_tready) take_edge(cur_edge);
    if (s_tvalid && !s_tready) begin
    end else if (src_gap > 0) begin
      src_gap <= src_gap - 1;
      s_tvalid <= 1'b0;
    end else if (rst_ni && edge_q.size() > 0) begin
      if (!quiet && $urandom_range(0, 7) == 0) begin
        src_gap <= $urandom_range(0, 4);
        s_tvalid <= 1'b0;
      end else begin
        cur_edge = edge_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, cur_edge.weight, cur_edge.node_b, cur_edge.node_a};
        s_tlast <= cur_edge.last_edge;
      end
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_cnt <= 20000;
      hold_done <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk_i) begin
    mwcf_res_t want;
    if (m_tvalid && m_tready) begin
      if (cycle_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: node %0d found %0b length %0d last %0b",
                   m_tdata[6:0], m_tuser, m_tdata[30:7], m_tlast);
      end else begin
        want = cycle_q.pop_front();
        if (m_tdata[6:0] !== want.node || m_tuser !== want.found ||
            m_tdata[30:7] !== want.cycle_length || m_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected node %0d found %0b length %0d last %0b",
                     want.node, want.found, want.cycle_length, want.last);
            $display("          got node %0d found %0b length %0d last %0b",
                     m_tdata[6:0], m_tuser, m_tdata[30:7], m_tlast);
          end
        end
      end
    end
    if ((hold_req && !hold_done) || hold_cnt > 0) begin
      m_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      sink_gap <= $urandom_range(0, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_edge(int a, int b, int w, bit last);
    mwcf_edge_t e;
    e.node_a = a[6:0];
    e.node_b = b[6:0];
    e.weight = w[15:0];
    e.last_edge = last;
    edge_q.push_back(e);
    total_items++;
  endtask

  function automatic int pick_node(int n);
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, (n < 1) ? 1 : n);
    return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 127);
  endfunction

  task automatic add_random_run(int n);
    int cnt, w;
    cnt = $urandom_range(1, 12);
    for (int i = 0; i < cnt; i++) begin
      w = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 15) : $urandom_range(0, 65535);
      add_edge(pick_node(n), pick_node(n), w, i == cnt - 1);
    end
  endtask

  task automatic write_count(int v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= v[6:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    count_m = int'(v[6:0]);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk_i); while (edge_q.size() > 0 || s_tvalid || cycle_q.size() > 0);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    int n;
    for (int i = 0; i < 4096; i++) edge_len[i] = INF_DIST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_count(127);
    add_edge(1, 2, 20, 0);
    add_edge(2, 1, 3, 0);
    add_edge(2, 3, 7, 0);
    add_edge(3, 1, 9, 0);
    add_edge(1, 2, 50, 0);
    add_edge(4, 4, 0, 0);
    add_edge(0, 5, 1, 0);
    add_edge(65, 1, 0, 0);
    add_edge(127, 127, 65535, 0);
    add_edge(62, 63, 0, 0);
    add_edge(63, 64, 0, 0);
    add_edge(64, 62, 65535, 0);
    add_edge(0, 127, 'hAAAA, 0);
    add_edge(6, 5, 'h5555, 1);
    drain();

    write_count(0);
    add_edge(1, 2, 1, 0);
    add_edge(2, 3, 1, 1);
    drain();
    write_count(1);
    add_edge(1, 1, 4, 1);
    drain();
    write_count(2);
    add_edge(1, 2, 4, 0);
    add_edge(0, 0, 0, 1);
    drain();
    write_count(3);
    add_edge(1, 2, 2, 0);
    add_edge(2, 3, 2, 0);
    add_edge(1, 3, 2, 0);
    add_edge(3, 4, 0, 1);
    drain();

    while (total_items < 270) begin
      if (total_items > 230) quiet = 1;
      case ($urandom_range(0, 9))
        0: n = $urandom_range(0, 2);
        1: n = $urandom_range(9, 12);
        default: n = $urandom_range(3, 8);
      endcase
      write_count(n);
      add_random_run(n);
      if (!hold_req && total_items > 120) begin
        add_random_run(n);
        hold_req = 1;
      end
      drain();
    end

    drain();
    if (mismatches == 0 && cycle_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
